/* rtl/ffa_pkg.sv */
// Shared types and constants of the first-fit heap allocator.
`default_nettype none
package ffa_pkg;
    localparam int ADDR_BITS   = 16;
    localparam int HANDLE_BITS = 8;
    localparam int STATUS_BITS = 3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_FREE_EMPTY = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_NO_FIT     = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_DUPLICATE  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_NONE_ALLOC = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND  = 3'd5;
    localparam logic [STATUS_BITS-1:0] ST_TABLE_FULL = 3'd6;

    localparam logic CFG_HEAP_BASE = 1'b0;
    localparam logic CFG_HEAP_SIZE = 1'b1;

    localparam logic [ADDR_BITS-1:0] HEAP_BASE_RESET = 16'd0;
    localparam logic [ADDR_BITS-1:0] HEAP_SIZE_RESET = 16'd2000;

    typedef struct packed {
        logic                   kind;
        logic [HANDLE_BITS-1:0] handle;
        logic [ADDR_BITS-1:0]   req_size;
    } ffa_req_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [ADDR_BITS-1:0]   block_start;
        logic [ADDR_BITS-1:0]   block_size;
    } ffa_rsp_t;
endpackage
`default_nettype wire

/* rtl/ffa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/first_fit_heap_allocator.sv */
// Top level of the first-fit heap allocator with coalescing.
// One transaction at a time. An allocation visits free segments, scans the allocation
// entries and shifts segments on removal.
// A free scans the allocation entries, visits free segments or shifts them, and then
// moves segments to make room at the head; each table is read through its one read port.
// Reset, and any configuration write, rebuild the tables in S_INIT.
`default_nettype none
module first_fit_heap_allocator
    import ffa_pkg::*;
#(
    parameter int ALLOC_ENTRIES = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire ffa_req_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output ffa_rsp_t                  out_data,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [ADDR_BITS-1:0] cfg_data
);
    localparam int FREE_ENTRIES = ALLOC_ENTRIES + 1;
    localparam int FAW = $clog2(FREE_ENTRIES);
    localparam int FCW = $clog2(FREE_ENTRIES + 1);
    localparam int AAW = $clog2(ALLOC_ENTRIES);
    localparam int ACW = $clog2(ALLOC_ENTRIES + 1);
    localparam int AW  = HANDLE_BITS + 2 * ADDR_BITS;

    typedef enum logic [14:0] {
        S_INIT     = 15'b000000000000001,
        S_IDLE     = 15'b000000000000010,
        S_F_RD     = 15'b000000000000100,
        S_F_CHK    = 15'b000000000001000,
        S_A_RD     = 15'b000000000010000,
        S_A_CHK    = 15'b000000000100000,
        S_CARVE    = 15'b000000001000000,
        S_SH_RD    = 15'b000000010000000,
        S_SH_WR    = 15'b000000100000000,
        S_REL_RD   = 15'b000001000000000,
        S_REL_CHK  = 15'b000010000000000,
        S_INS_RD   = 15'b000100000000000,
        S_INS_WR   = 15'b001000000000000,
        S_INS_HEAD = 15'b010000000000000,
        S_RESP     = 15'b100000000000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [ADDR_BITS-1:0]     base_reg, base_next, hsize_reg, hsize_next;
    logic [FCW-1:0]           cnt_reg, cnt_next, idx_reg, idx_next, sh_reg, sh_next;
    logic [ACW-1:0]           acnt_reg, acnt_next, aidx_reg, aidx_next;
    logic [AAW-1:0]           slot_reg, slot_next;
    logic                     slot_found_reg, slot_found_next;
    logic [ALLOC_ENTRIES-1:0] valid_reg, valid_next;
    logic                     kind_reg, kind_next;
    logic [HANDLE_BITS-1:0]   hdl_reg, hdl_next;
    logic [ADDR_BITS-1:0]     req_reg, req_next;
    logic [ADDR_BITS-1:0]     seg_s_reg, seg_s_next, seg_z_reg, seg_z_next;
    logic [ADDR_BITS-1:0]     s_reg, s_next, n_reg, n_next;
    ffa_rsp_t                 res_reg, res_next;
    logic                     out_valid_reg, out_valid_next;
    ffa_rsp_t                 out_reg, out_next;

    logic                     fw_en, aw_en;
    logic [FAW-1:0]           fw_addr, fr_addr;
    logic [2*ADDR_BITS-1:0]   fw_data, fr_data;
    logic [AAW-1:0]           ar_addr;
    logic [AW-1:0]            aw_data, ar_data;

    logic [ADDR_BITS:0]       clip_sum;
    logic [ADDR_BITS-1:0]     clip_size;
    logic [ADDR_BITS-1:0]     rd_st, rd_sz, a_st, a_sz;
    logic [HANDLE_BITS-1:0]   a_hdl;
    logic                     a_hit;

    ffa_ram #(.WIDTH(2 * ADDR_BITS), .DEPTH(FREE_ENTRIES)) u_free_ram (
        .clk   (clk),
        .we    (fw_en),
        .waddr (fw_addr),
        .wdata (fw_data),
        .raddr (fr_addr),
        .rdata (fr_data)
    );

    ffa_ram #(.WIDTH(AW), .DEPTH(ALLOC_ENTRIES)) u_alloc_ram (
        .clk   (clk),
        .we    (aw_en),
        .waddr (slot_reg),
        .wdata (aw_data),
        .raddr (ar_addr),
        .rdata (ar_data)
    );

    assign clip_sum  = {1'b0, base_reg} + {1'b0, hsize_reg};
    assign clip_size = (clip_sum[ADDR_BITS] && (clip_sum[ADDR_BITS-1:0] != '0))
                       ? ADDR_BITS'(~base_reg + 1'b1) : hsize_reg;
    assign {rd_st, rd_sz}        = fr_data;
    assign {a_hdl, a_st, a_sz}   = ar_data;
    assign a_hit    = valid_reg[aidx_reg[AAW-1:0]] && (a_hdl == hdl_reg);
    assign aw_data  = {hdl_reg, seg_s_reg, req_reg};
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        hsize_next      = hsize_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        sh_next         = sh_reg;
        acnt_next       = acnt_reg;
        aidx_next       = aidx_reg;
        slot_next       = slot_reg;
        slot_found_next = slot_found_reg;
        valid_next      = valid_reg;
        kind_next       = kind_reg;
        hdl_next        = hdl_reg;
        req_next        = req_reg;
        seg_s_next      = seg_s_reg;
        seg_z_next      = seg_z_reg;
        s_next          = s_reg;
        n_next          = n_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        fw_en           = 1'b0;
        fw_addr         = idx_reg[FAW-1:0];
        fw_data         = {seg_s_reg, seg_z_reg};
        fr_addr         = idx_reg[FAW-1:0];
        aw_en           = 1'b0;
        ar_addr         = aidx_reg[AAW-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                fw_en      = 1'b1;
                fw_addr    = '0;
                fw_data    = {base_reg, clip_size};
                cnt_next   = (clip_size != '0) ? FCW'(1) : '0;
                valid_next = '0;
                acnt_next  = '0;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next       = in_data.kind;
                    hdl_next        = in_data.handle;
                    req_next        = in_data.req_size;
                    res_next        = '{status: ST_OK, block_start: '0, block_size: '0};
                    idx_next        = '0;
                    aidx_next       = '0;
                    slot_found_next = 1'b0;
                    if (in_data.kind == KIND_ALLOC)
                    begin
                        if (cnt_reg == '0)
                        begin
                            res_next.status = ST_FREE_EMPTY;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            state_next = S_F_RD;
                        end
                    end
                    else
                    begin
                        if (acnt_reg == '0)
                        begin
                            res_next.status = ST_NONE_ALLOC;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            state_next = S_A_RD;
                        end
                    end
                end
            end
            S_F_RD:
            begin
                if (idx_reg < cnt_reg)
                begin
                    state_next = S_F_CHK;
                end
                else
                begin
                    res_next.status = ST_NO_FIT;
                    state_next      = S_RESP;
                end
            end
            S_F_CHK:
            begin
                if (rd_sz >= req_reg)
                begin
                    seg_s_next = rd_st;
                    seg_z_next = rd_sz;
                    state_next = S_A_RD;
                end
                else
                begin
                    idx_next   = FCW'(idx_reg + 1'b1);
                    state_next = S_F_RD;
                end
            end
            S_A_RD:
            begin
                if (aidx_reg < ACW'(ALLOC_ENTRIES))
                begin
                    state_next = S_A_CHK;
                end
                else if (kind_reg == KIND_FREE)
                begin
                    res_next.status = ST_NOT_FOUND;
                    state_next      = S_RESP;
                end
                else if (!slot_found_reg)
                begin
                    res_next.status = ST_TABLE_FULL;
                    state_next      = S_RESP;
                end
                else
                begin
                    state_next = S_CARVE;
                end
            end
            S_A_CHK:
            begin
                aidx_next  = ACW'(aidx_reg + 1'b1);
                state_next = S_A_RD;
                if (kind_reg == KIND_ALLOC)
                begin
                    if (a_hit)
                    begin
                        res_next.status = ST_DUPLICATE;
                        state_next      = S_RESP;
                    end
                    else if (!valid_reg[aidx_reg[AAW-1:0]] && !slot_found_reg)
                    begin
                        slot_next       = aidx_reg[AAW-1:0];
                        slot_found_next = 1'b1;
                    end
                end
                else if (a_hit)
                begin
                    s_next                           = a_st;
                    n_next                           = a_sz;
                    res_next.block_start             = a_st;
                    res_next.block_size              = a_sz;
                    valid_next[aidx_reg[AAW-1:0]]    = 1'b0;
                    acnt_next                        = ACW'(acnt_reg - 1'b1);
                    idx_next                         = '0;
                    state_next = (a_sz != '0) ? S_REL_RD : S_RESP;
                end
            end
            S_CARVE:
            begin
                aw_en                = 1'b1;
                valid_next[slot_reg] = 1'b1;
                acnt_next            = ACW'(acnt_reg + 1'b1);
                res_next.block_start = seg_s_reg;
                res_next.block_size  = req_reg;
                if (seg_z_reg == req_reg && req_reg != '0)
                begin
                    sh_next    = idx_reg;
                    state_next = S_SH_RD;
                end
                else
                begin
                    fw_en      = 1'b1;
                    fw_data    = {ADDR_BITS'(seg_s_reg + req_reg),
                                  ADDR_BITS'(seg_z_reg - req_reg)};
                    state_next = S_RESP;
                end
            end
            S_SH_RD:
            begin
                fr_addr = FAW'(sh_reg + 1'b1);
                if (FCW'(sh_reg + 1'b1) < cnt_reg)
                begin
                    state_next = S_SH_WR;
                end
                else
                begin
                    cnt_next   = FCW'(cnt_reg - 1'b1);
                    state_next = (kind_reg == KIND_FREE) ? S_REL_RD : S_RESP;
                end
            end
            S_SH_WR:
            begin
                fw_en      = 1'b1;
                fw_addr    = sh_reg[FAW-1:0];
                fw_data    = fr_data;
                sh_next    = FCW'(sh_reg + 1'b1);
                state_next = S_SH_RD;
            end
            S_REL_RD:
            begin
                if (idx_reg < cnt_reg)
                begin
                    state_next = S_REL_CHK;
                end
                else if (cnt_reg >= FCW'(FREE_ENTRIES))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    sh_next    = cnt_reg;
                    state_next = S_INS_RD;
                end
            end
            S_REL_CHK:
            begin
                sh_next = idx_reg;
                if (({1'b0, rd_st} + {1'b0, rd_sz}) == {1'b0, s_reg})
                begin
                    s_next     = rd_st;
                    n_next     = ADDR_BITS'(n_reg + rd_sz);
                    state_next = S_SH_RD;
                end
                else if (({1'b0, s_reg} + {1'b0, n_reg}) == {1'b0, rd_st})
                begin
                    n_next     = ADDR_BITS'(n_reg + rd_sz);
                    state_next = S_SH_RD;
                end
                else
                begin
                    idx_next   = FCW'(idx_reg + 1'b1);
                    state_next = S_REL_RD;
                end
            end
            S_INS_RD:
            begin
                fr_addr = FAW'(sh_reg - 1'b1);
                state_next = (sh_reg != '0) ? S_INS_WR : S_INS_HEAD;
            end
            S_INS_WR:
            begin
                fw_en      = 1'b1;
                fw_addr    = sh_reg[FAW-1:0];
                fw_data    = fr_data;
                sh_next    = FCW'(sh_reg - 1'b1);
                state_next = S_INS_RD;
            end
            S_INS_HEAD:
            begin
                fw_en      = 1'b1;
                fw_addr    = '0;
                fw_data    = {s_reg, n_reg};
                cnt_next   = FCW'(cnt_reg + 1'b1);
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        if (cfg_we)
        begin
            if (cfg_index == CFG_HEAP_BASE)
            begin
                base_next = cfg_data;
            end
            else
            begin
                hsize_next = cfg_data;
            end
            state_next = S_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            base_reg      <= HEAP_BASE_RESET;
            hsize_reg     <= HEAP_SIZE_RESET;
            cnt_reg       <= '0;
            acnt_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            hsize_reg     <= hsize_next;
            cnt_reg       <= cnt_next;
            acnt_reg      <= acnt_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        sh_reg         <= sh_next;
        aidx_reg       <= aidx_next;
        slot_reg       <= slot_next;
        slot_found_reg <= slot_found_next;
        kind_reg       <= kind_next;
        hdl_reg        <= hdl_next;
        req_reg        <= req_next;
        seg_s_reg      <= seg_s_next;
        seg_z_reg      <= seg_z_next;
        s_reg          <= s_next;
        n_reg          <= n_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FCW'(FREE_ENTRIES))
        else $error("Free segment count exceeds the table depth.");

    a_acnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acnt_reg <= ACW'(ALLOC_ENTRIES))
        else $error("Allocation count exceeds the table depth.");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != ST_OK)
        |-> (out_data.block_start == '0 && out_data.block_size == '0))
        else $error("An error transaction carries a nonzero block.");
`endif
endmodule
`default_nettype wire
